@@ design/u8d_pkg.sv @@
// Shared types, constants and byte classification helpers for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

   // Result status codes.
   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_ERR = 2'd1;
   localparam logic [1:0] STATUS_END = 2'd2;

   // Largest Unicode scalar value.
   localparam logic [30:0] MAX_CODE_POINT = 31'h10FFFF;

   // Queue between the front and the back; the depth must be a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   // One input beat.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [20:0] code_point;
      logic [1:0]  status;
   } rsp_type;

   // A classified input byte, as the front hands it to the back.
   typedef struct packed {
      logic       stream_end;
      logic       ascii;
      logic       bad_lead;
      logic [2:0] lead_len;
      logic [6:0] lead_bits;
      logic       cont_ok;
      logic [5:0] cont_bits;
   } class_type;

   // Number of continuation bytes that a lead byte of 0xC2 or above announces.
   function automatic logic [2:0] lead_length(input logic [7:0] c);
      logic [2:0] len;
      if (c < 8'hE0) begin
         len = 3'd1;
      end else if (c < 8'hF0) begin
         len = 3'd2;
      end else if (c < 8'hF8) begin
         len = 3'd3;
      end else if (c < 8'hFC) begin
         len = 3'd4;
      end else begin
         len = 3'd5;
      end
      return len;
   endfunction

   // Payload mask of a lead byte, by its continuation count.
   function automatic logic [7:0] lead_mask(input logic [2:0] len);
      logic [7:0] mask;
      case (len)
         3'd1:    mask = 8'h1F;
         3'd2:    mask = 8'h0F;
         3'd3:    mask = 8'h07;
         3'd4:    mask = 8'h03;
         default: mask = 8'h01;
      endcase
      return mask;
   endfunction

endpackage

@@ design/utf8_stream_decoder.sv @@
// Each accepted byte is registered in the queue, then decoded in the back end into the result register.
// Throughput: one byte or end mark per cycle while the result register is free or being drained.
// A four-entry queue lets the input keep flowing while a result waits on the output.
// Reset (synchronous, active high) empties the queue, drops any pending result and
// returns the decoder to a character boundary with a cleared accumulator.
`timescale 1ns / 1ps

module utf8_stream_decoder
   import u8d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      push_valid, push_ready;
   class_type push_data;
   logic      pop_valid, pop_ready;
   class_type pop_data;

   u8d_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   u8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   u8d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/u8d_front.sv @@
// Front end: accepts input beats and classifies each byte for the back end.
`timescale 1ns / 1ps

module u8d_front
   import u8d_pkg::*;
(
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      push_valid,
   input  logic      push_ready,
   output class_type push_data
);

   logic [2:0] len;
   logic [7:0] masked;

   // Handshake passes straight through to the queue.
   assign push_valid = req_valid;
   assign req_ready  = push_ready;

   // Every possible role of the byte is worked out here; the back picks one by its state.
   always_comb begin
      len    = lead_length(req_data.data_byte);
      masked = req_data.data_byte & lead_mask(len);

      push_data.stream_end = req_data.stream_end;
      push_data.ascii      = ~req_data.data_byte[7];
      push_data.bad_lead   = req_data.data_byte[7] && (req_data.data_byte < 8'hC2);
      push_data.lead_len   = len;
      push_data.lead_bits  = req_data.data_byte[7] ? masked[6:0] : req_data.data_byte[6:0];
      push_data.cont_ok    = (req_data.data_byte[7:6] == 2'b10);
      push_data.cont_bits  = req_data.data_byte[5:0];
   end

endmodule

@@ design/u8d_queue.sv @@
// Short queue of classified bytes between the front end and the back end.
`timescale 1ns / 1ps

module u8d_queue
   import u8d_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  class_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output class_type pop_data
);

   class_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointers wrap on their own since the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/u8d_back.sv @@
// Back end: sequence state, character assembly, validation and the result register.
`timescale 1ns / 1ps

module u8d_back
   import u8d_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  class_type pop_data,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic [2:0]  remaining_ff, remaining_in;
   logic [30:0] acc_ff, acc_in;
   logic        bad_ff, bad_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        take;
   logic        emit;
   rsp_type     result;
   logic [30:0] acc_next;
   logic        bad_next;
   logic [2:0]  remaining_next;

   // A beat is taken whenever the result register is free or being drained.
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Decode one classified byte against the current sequence state.
   always_comb begin
      remaining_in      = remaining_ff;
      acc_in            = acc_ff;
      bad_in            = bad_ff;
      emit              = 1'b0;
      result.code_point = '0;
      result.status     = STATUS_OK;
      acc_next          = {acc_ff[24:0], pop_data.cont_bits};
      bad_next          = bad_ff || !pop_data.cont_ok;
      remaining_next    = remaining_ff - 1'b1;

      if (pop_data.stream_end) begin
         emit = 1'b1;
         if (remaining_ff == '0) begin
            result.status = STATUS_END;
         end else begin
            result.status = STATUS_ERR;
            remaining_in  = '0;
            acc_in        = '0;
            bad_in        = 1'b0;
         end
      end else if (remaining_ff == '0) begin
         if (pop_data.ascii) begin
            emit              = 1'b1;
            result.code_point = {14'd0, pop_data.lead_bits};
         end else if (pop_data.bad_lead) begin
            emit          = 1'b1;
            result.status = STATUS_ERR;
         end else begin
            acc_in       = {24'd0, pop_data.lead_bits};
            remaining_in = pop_data.lead_len;
            bad_in       = 1'b0;
         end
      end else begin
         remaining_in = remaining_next;
         acc_in       = acc_next;
         bad_in       = bad_next;
         // Last continuation byte: check and report the character.
         if (remaining_next == '0) begin
            emit   = 1'b1;
            acc_in = '0;
            bad_in = 1'b0;
            if (bad_next || acc_next > MAX_CODE_POINT) begin
               result.status = STATUS_ERR;
            end else begin
               result.code_point = acc_next[20:0];
            end
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         acc_ff       <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            remaining_ff <= remaining_in;
            acc_ff       <= acc_in;
            bad_ff       <= bad_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ sim/utf8_stream_decoder_test.sv @@
// Self-checking testbench for the UTF-8 stream decoder with randomized byte streams.
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
   import u8d_pkg::*;

   localparam int ITEM_TARGET = 1925;
   localparam int CALM_TAIL   = 200;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;
   localparam int DRAIN_GAP   = 700;

   // One queued input beat, optionally held back until all results are in.
   typedef struct {
      req_type beat;
      logic    drain_before;
   } stim_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_entry_type pending_beats[$];
   rsp_type        expected_chars[$];

   // Decoder state mirrored by the predictor.
   logic [2:0]  conts_left = '0;
   logic [30:0] char_acc = '0;
   logic        cont_broken = 1'b0;

   logic req_taken = 1'b0;
   int   send_idle = 0;
   int   recv_idle = 0;
   int   mismatch_count = 0;
   int   cycle_count = 0;

   utf8_stream_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Abort a run that hangs.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Advance the decoder mirror by one beat and record the character it yields.
   task automatic decode_beat(input req_type beat);
      rsp_type    res;
      logic [2:0] seq_len;
      res = '0;
      if (beat.stream_end) begin
         res.status = (conts_left == 3'd0) ? STATUS_END : STATUS_ERR;
         expected_chars.push_back(res);
         conts_left = '0;
         if (res.status == STATUS_ERR) begin
            char_acc = '0;
            cont_broken = 1'b0;
         end
      end else if (conts_left == 3'd0) begin
         if (!beat.data_byte[7]) begin
            res.code_point = {13'd0, beat.data_byte};
            res.status = STATUS_OK;
            expected_chars.push_back(res);
         end else if (beat.data_byte < 8'hC2) begin
            res.status = STATUS_ERR;
            expected_chars.push_back(res);
         end else begin
            // The run of ones after the 11 prefix sets the sequence length.
            casez (beat.data_byte[5:2])
               4'b0???: seq_len = 3'd1;
               4'b10??: seq_len = 3'd2;
               4'b110?: seq_len = 3'd3;
               4'b1110: seq_len = 3'd4;
               default: seq_len = 3'd5;
            endcase
            char_acc = {23'd0, beat.data_byte & (8'hFF >> (seq_len + 3'd2))};
            conts_left = seq_len;
            cont_broken = 1'b0;
         end
      end else begin
         if (beat.data_byte[7:6] != 2'b10) begin
            cont_broken = 1'b1;
         end
         char_acc = {char_acc[24:0], beat.data_byte[5:0]};
         conts_left = conts_left - 3'd1;
         if (conts_left == 3'd0) begin
            if (cont_broken || char_acc > MAX_CODE_POINT) begin
               res.status = STATUS_ERR;
            end else begin
               res.code_point = char_acc[20:0];
               res.status = STATUS_OK;
            end
            expected_chars.push_back(res);
            char_acc = '0;
            cont_broken = 1'b0;
         end
      end
   endtask

   task automatic queue_beat(input logic [7:0] data, input logic is_end);
      stim_entry_type item;
      item.beat.data_byte = data;
      item.beat.stream_end = is_end;
      item.drain_before = 1'b0;
      pending_beats.push_back(item);
   endtask

   // Encode a value with the given number of continuation bytes (overlong forms
   // allowed), emit only the first keep of them, and optionally spoil one.
   task automatic queue_char(input logic [30:0] value, input int nconts, input int keep,
                             input int spoil_at);
      logic [31:0] wide;
      logic [7:0]  lead;
      logic [7:0]  cont;
      wide = {1'b0, value};
      if (nconts == 0) begin
         queue_beat({1'b0, value[6:0]}, 1'b0);
      end else begin
         lead = ~(8'hFF >> (nconts + 1)) | (8'(wide >> (6 * nconts)) & (8'hFF >> (nconts + 2)));
         queue_beat(lead, 1'b0);
         for (int i = 0; i < keep; i++) begin
            cont = 8'h80 | (8'(wide >> (6 * (nconts - 1 - i))) & 8'h3F);
            if (i == spoil_at) begin
               cont[7:6] = cont[7:6] ^ 2'($urandom_range(1, 3));
            end
            queue_beat(cont, 1'b0);
         end
      end
   endtask

   function automatic logic [30:0] random_payload(input int nconts);
      logic [31:0] mask;
      mask = (32'd1 << (5 * nconts + 6)) - 32'd1;
      if (nconts == 0) begin
         mask = 32'h7F;
      end
      if ($urandom_range(0, 1) == 1) begin
         return 31'($urandom_range(0, 32'h10FFFF) & mask);
      end
      return 31'($urandom & mask);
   endfunction

   // Sender: presents queued beats at the falling edge and idles in bursts.
   always @(negedge clock) begin : drive
      stim_entry_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_idle > 0) begin
            send_idle = send_idle - 1;
            req_valid <= 1'b0;
         end else if (pending_beats.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_beats[0].drain_before && expected_chars.size() != 0) begin
            req_valid <= 1'b0;
         end else if (pending_beats.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
            send_idle = $urandom_range(0, 10);
            req_valid <= 1'b0;
         end else begin
            next_item = pending_beats.pop_front();
            req_data <= next_item.beat;
            req_valid <= 1'b1;
         end
      end
   end

   // Receiver: stalls the result channel in bursts except near the end.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_idle > 0) begin
         recv_idle = recv_idle - 1;
         rsp_ready <= 1'b0;
      end else if (pending_beats.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
         recv_idle = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predicts on each accepted byte beat and checks each result beat.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            decode_beat(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               if (mismatch_count < REPORT_MAX) begin
                  $display("Unexpected result at cycle %0d: code_point=%h status=%0d",
                           cycle_count, rsp_data.code_point, rsp_data.status);
               end
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.code_point !== want.code_point || rsp_data.status !== want.status)
               begin
                  if (mismatch_count < REPORT_MAX) begin
                     $display("Mismatch at cycle %0d: expected code_point=%h status=%0d, %s",
                              cycle_count, want.code_point, want.status, "got");
                     $display("   code_point=%h status=%0d",
                              rsp_data.code_point, rsp_data.status);
                  end
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int kind;
      int nconts;
      int drain_marks;

      // Directed part: field extremes and the special cases.
      queue_beat(8'h00, 1'b0);
      queue_beat(8'h7F, 1'b0);
      queue_beat(8'h80, 1'b0);
      queue_beat(8'hC1, 1'b0);
      queue_beat(8'hFF, 1'b1);
      queue_beat(8'h00, 1'b1);
      queue_char(31'h80, 1, 1, -1);
      queue_char(31'h10FFFF, 3, 3, -1);
      queue_char(31'h110000, 3, 3, -1);
      queue_beat(8'hE0, 1'b0);
      queue_beat(8'h55, 1'b1);
      // Highest lead with a spoiled continuation in the middle.
      queue_beat(8'hFF, 1'b0);
      queue_beat(8'h80, 1'b0);
      queue_beat(8'h80, 1'b0);
      queue_beat(8'hC0, 1'b0);
      queue_beat(8'h80, 1'b0);
      queue_beat(8'h80, 1'b0);
      queue_char(31'h41, 5, 5, -1);
      pending_beats[pending_beats.size() - 1].drain_before = 1'b1;

      // Random part: mostly well-formed characters, mixed with noise and broken runs.
      drain_marks = 1;
      while (pending_beats.size() < ITEM_TARGET) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            nconts = $urandom_range(0, 5);
            queue_char(random_payload(nconts), nconts, nconts, -1);
         end else if (kind < 72) begin
            nconts = $urandom_range(1, 5);
            queue_char(random_payload(nconts), nconts, nconts, $urandom_range(0, nconts - 1));
         end else if (kind < 80) begin
            nconts = $urandom_range(1, 5);
            queue_char(random_payload(nconts), nconts, $urandom_range(0, nconts - 1), -1);
            if ($urandom_range(0, 1) == 1) begin
               queue_beat(8'($urandom), 1'b1);
            end
         end else if (kind < 92) begin
            queue_beat(8'($urandom), 1'b0);
         end else begin
            queue_beat(8'($urandom), 1'b1);
         end
         if (pending_beats.size() >= DRAIN_GAP * drain_marks) begin
            pending_beats[pending_beats.size() - 1].drain_before = 1'b1;
            drain_marks = drain_marks + 1;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      while (expected_chars.size() != 0) begin
         @(negedge clock);
      end
      repeat (10) @(negedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
